[design/hkvt_pkg.sv]
// package for the hashed key/value table: transaction types, status codes, fnv constants
// no dependencies
`default_nettype none
package hkvt_pkg;
    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_MULT  = 64'h00000100000001B3;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic        op;
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
        logic [31:0] entry_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic        added_new;
    } t_rsp;

    // classified request handed from front to back
    typedef struct packed {
        logic        op;
        logic [63:0] key;
        logic [3:0]  len;
        logic [31:0] value;
        logic [63:0] hash;
    } t_job;
endpackage
`default_nettype wire

[design/hkvt_ram.sv]
// generic single-port-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module hkvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[design/hkvt_front.sv]
// front part: accepts requests, normalizes key, computes fnv-1a one byte per step
// depends on hkvt_pkg
`default_nettype none
module hkvt_front
    import hkvt_pkg::*;
#(
    parameter int KEY_MAX_BYTES = 8,
    parameter int VALUE_BITS    = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_job
);
    typedef enum logic [1:0] {S_IDLE, S_HASH, S_MUL, S_DONE} t_state;

    t_state      r_state;
    t_job        r_job;
    logic [3:0]  r_cnt;
    logic [63:0] r_x;
    logic [3:0]  n_len;
    logic [63:0] n_key;
    logic [7:0]  w_byte;

    // saturate length and clear stray bytes
    always_comb begin
        n_len = (i_req.key_length > 4'(KEY_MAX_BYTES)) ? 4'(KEY_MAX_BYTES)
                                                        : i_req.key_length;
        for (int b = 0; b < 8; b++) begin
            n_key[b*8 +: 8] = (4'(b) < n_len) ? i_req.key_bytes[b*8 +: 8] : 8'd0;
        end
    end

    assign w_byte  = r_job.key[{r_cnt[2:0], 3'b000} +: 8];
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_job   = r_job;

    // hash sequencer: xor step, then registered multiply step
    // fnv prime is 2^40 + 0x1b3, so the multiply is a sum of shifted copies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job.op    <= i_req.op;
                        r_job.key   <= n_key;
                        r_job.len   <= n_len;
                        r_job.value <= i_req.entry_value
                                       & 32'(~64'd0 >> (64 - VALUE_BITS));
                        r_job.hash  <= FNV_BASIS;
                        r_cnt       <= '0;
                        r_state     <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (r_cnt == r_job.len) begin
                        r_state <= S_DONE;
                    end else begin
                        r_x     <= r_job.hash ^ {56'd0, w_byte};
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_job.hash <= (r_x << 40) + (r_x << 8) + (r_x << 7) + (r_x << 5)
                                  + (r_x << 4) + (r_x << 1) + r_x;
                    r_cnt      <= r_cnt + 4'd1;
                    r_state    <= S_HASH;
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // counter never runs past the key length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> r_cnt < r_job.len)
        else $error("hash counter overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_job))
        else $error("job changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && i_valid |=> r_state == S_HASH)
        else $error("accept did not start hashing");
endmodule
`default_nettype wire

[design/hkvt_fifo.sv]
// two-entry queue between front and back parts
// depends on hkvt_pkg
`default_nettype none
module hkvt_fifo
    import hkvt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_job
);
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers out of step");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count missed a push");
endmodule
`default_nettype wire

[design/hkvt_back.sv]
// back part: linear probe over the slot memory, then lookup or set
// depends on hkvt_pkg and hkvt_ram
`default_nettype none
module hkvt_back
    import hkvt_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_rsp      o_rsp
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = 64 + 4 + VALUE_BITS;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_DONE} t_state;

    t_state          r_state;
    t_job            r_job;
    logic [IW-1:0]   r_idx;
    logic [CW-1:0]   r_probes;
    logic [CW-1:0]   r_occ;
    logic [SLOTS-1:0] r_valid;
    t_rsp            r_rsp;
    logic            w_we;
    logic [EW-1:0]   w_wdata;
    logic [EW-1:0]   w_rdata;
    logic [63:0]     w_skey;
    logic [3:0]      w_slen;
    logic [VALUE_BITS-1:0] w_sval;
    logic            w_hit;
    logic [CW-1:0]   n_probes;

    assign {w_skey, w_slen, w_sval} = w_rdata;
    assign w_hit    = (w_slen == r_job.len) && (w_skey == r_job.key);
    assign n_probes = r_probes + CW'(1);
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_DONE);
    assign o_rsp    = r_rsp;

    // slot write: key and length preserved on overwrite
    always_comb begin
        w_we    = 1'b0;
        w_wdata = {r_job.key, r_job.len, r_job.value[VALUE_BITS-1:0]};
        if (r_state == S_CHECK && r_job.op) begin
            if (r_valid[r_idx] && w_hit) begin
                w_we = 1'b1;
            end else if (!r_valid[r_idx] && r_occ < CW'(SLOTS / 2)) begin
                w_we = 1'b1;
            end
        end
    end

    hkvt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slots (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_idx),
        .i_wdata(w_wdata),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    // probe sequencer, valid bits and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_occ   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job    <= i_job;
                        r_idx    <= i_job.hash[IW-1:0];
                        r_probes <= '0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    r_rsp.found_value <= '0;
                    r_rsp.added_new   <= 1'b0;
                    r_state           <= S_DONE;
                    if (!r_valid[r_idx]) begin
                        if (!r_job.op) begin
                            r_rsp.status <= ST_MISS;
                        end else if (r_occ >= CW'(SLOTS / 2)) begin
                            r_rsp.status <= ST_FULL;
                        end else begin
                            r_rsp.status    <= ST_OK;
                            r_rsp.added_new <= 1'b1;
                            r_valid[r_idx]  <= 1'b1;
                            r_occ           <= r_occ + CW'(1);
                        end
                    end else if (w_hit) begin
                        r_rsp.status <= ST_OK;
                        if (!r_job.op) begin
                            r_rsp.found_value <= 32'(w_sval);
                        end
                    end else if (n_probes == CW'(SLOTS)) begin
                        r_rsp.status <= r_job.op ? ST_FULL : ST_MISS;
                    end else begin
                        r_probes <= n_probes;
                        r_idx    <= r_idx + IW'(1);
                        r_state  <= S_READ;
                    end
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_occ))
        else $error("occupancy disagrees with valid bits");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(SLOTS / 2))
        else $error("occupancy above half");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.added_new |-> o_rsp.status == ST_OK)
        else $error("new slot with bad status");
endmodule
`default_nettype wire

[design/hashed_key_value_table_unit.sv]
// hashed key/value table, fnv-1a hash with linear probing over SLOTS slots
// a request passes through the hash front, then the queue, then the table probe
// the front can hash a new request while the back still probes an earlier one; parts overlap via queue
// probes are at most half the slots plus one while the full limit holds
// reset clears all valid bits and occupancy at once; no clearing pass needed
// depends on hkvt_pkg, hkvt_front, hkvt_fifo, hkvt_back, hkvt_ram
`default_nettype none
module hashed_key_value_table_unit
    import hkvt_pkg::*;
#(
    parameter int SLOTS         = 16,
    parameter int KEY_MAX_BYTES = 8,
    parameter int VALUE_BITS    = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_rsp      o_rsp
);
    logic w_fv, w_fr, w_qv, w_qr;
    t_job w_fjob, w_qjob;

    hkvt_front #(.KEY_MAX_BYTES(KEY_MAX_BYTES), .VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(w_fv), .i_ready(w_fr), .o_job(w_fjob)
    );

    hkvt_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fv), .o_ready(w_fr), .i_job(w_fjob),
        .o_valid(w_qv), .i_ready(w_qr), .o_job(w_qjob)
    );

    hkvt_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_job(w_qjob),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );
endmodule
`default_nettype wire

[bench/testbench.sv]
// testbench for hashed_key_value_table_unit: directed table then random lookup/set traffic
// predicts responses with an fnv-1a linear-probe table model or typed-in directed responses; depends on hkvt_pkg
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import hkvt_pkg::*;

    localparam int SLOTS      = 16;
    localparam int KEY_MAX    = 8;
    localparam int DIR_ROWS   = 16;
    localparam int RAND_ITEMS = 1850;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_req i_req;
    logic o_valid;
    logic i_ready;
    t_rsp o_rsp;

    hashed_key_value_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    // table model state
    logic        tbl_valid [SLOTS];
    logic [63:0] tbl_key   [SLOTS];
    logic [3:0]  tbl_len   [SLOTS];
    logic [31:0] tbl_value [SLOTS];
    int          tbl_count;

    t_rsp pending_rsp[$];
    int   errors;
    bit   stim_done;
    bit   long_hold;
    int   idle_cycles;

    // key pool so random traffic revisits the same keys
    logic [63:0] pool_key [24];
    logic [3:0]  pool_len [24];

    // directed rows and typed-in responses (mask bit set when response is known)
    t_req dir_req   [DIR_ROWS];
    t_rsp dir_rsp   [DIR_ROWS];
    bit   dir_known [DIR_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // model one request, update state, return expected response
    function automatic t_rsp table_access(t_req req);
        t_rsp        rsp;
        logic [3:0]  len;
        logic [63:0] key;
        logic [63:0] hash;
        int          idx;
        bit          hit;
        bit          empty;
        len = (req.key_length > KEY_MAX) ? 4'(KEY_MAX) : req.key_length;
        key = (len == 0) ? 64'd0 : req.key_bytes & (~64'd0 >> (64 - 8 * len));
        hash = FNV_BASIS;
        for (int i = 0; i < len; i++) begin
            hash = (hash ^ 64'(key[8*i +: 8])) * FNV_MULT;
        end
        idx = int'(hash[3:0]);
        hit = 0;
        empty = 0;
        for (int p = 0; p < SLOTS; p++) begin
            if (!tbl_valid[idx]) begin
                empty = 1;
                break;
            end
            if (tbl_len[idx] == len && tbl_key[idx] == key) begin
                hit = 1;
                break;
            end
            idx = (idx + 1) % SLOTS;
        end
        rsp = '0;
        if (!req.op) begin
            rsp.status = hit ? ST_OK : ST_MISS;
            if (hit) rsp.found_value = tbl_value[idx];
        end else if (hit) begin
            tbl_value[idx] = req.entry_value;
            rsp.status = ST_OK;
        end else if (tbl_count >= SLOTS / 2 || !empty) begin
            rsp.status = ST_FULL;
        end else begin
            tbl_valid[idx] = 1;
            tbl_key[idx]   = key;
            tbl_len[idx]   = len;
            tbl_value[idx] = req.entry_value;
            tbl_count++;
            rsp.status = ST_OK;
            rsp.added_new = 1'b1;
        end
        return rsp;
    endfunction

    // offer one transaction and wait for acceptance; caller drops valid
    task automatic send_request(t_req req);
        i_req   <= req;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic t_req random_request();
        t_req req;
        int   k;
        req.op = ($urandom_range(0, 9) < 5);
        if ($urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, 23);
            req.key_bytes  = pool_key[k] | ($urandom_range(0, 3) == 0 ?
                             {$urandom, $urandom} & ~(~64'd0 >> (64 - 8 * pool_len[k]) |
                             (pool_len[k] == 0 ? 64'd0 : 64'd0)) : 64'd0);
            req.key_length = pool_len[k];
            if (pool_len[k] == 0) req.key_bytes = {$urandom, $urandom};
            if (pool_len[k] == KEY_MAX && $urandom_range(0, 3) == 0)
                req.key_length = 4'($urandom_range(KEY_MAX, 15));
        end else begin
            req.key_bytes  = {$urandom, $urandom};
            req.key_length = 4'($urandom_range(0, 15));
        end
        req.entry_value = $urandom;
        return req;
    endfunction

    // stimulus
    initial begin
        t_req req;
        int   burst;
        bit   hold_sent;
        bit   drained;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_req     = '0;
        errors    = 0;
        stim_done = 0;
        long_hold = 0;
        hold_sent = 0;
        drained   = 0;
        tbl_count = 0;
        for (int s = 0; s < SLOTS; s++) begin
            tbl_valid[s] = 0; tbl_key[s] = '0; tbl_len[s] = '0; tbl_value[s] = '0;
        end
        for (int k = 0; k < 24; k++) begin
            pool_len[k] = 4'($urandom_range(0, KEY_MAX));
            pool_key[k] = (pool_len[k] == 0) ? 64'd0 :
                          {$urandom, $urandom} & (~64'd0 >> (64 - 8 * pool_len[k]));
        end
        // directed: empty key, extremes, stray bytes, long key, zero bytes, full table
        dir_req[0]  = '{1'b0, 64'd0, 4'd0, 32'd0};
        dir_req[1]  = '{1'b1, ~64'd0, 4'd0, ~32'd0};
        dir_req[2]  = '{1'b0, 64'h1234, 4'd0, 32'd0};
        dir_req[3]  = '{1'b1, ~64'd0, 4'd15, 32'hA5A5_5A5A};
        dir_req[4]  = '{1'b0, ~64'd0, 4'd8, 32'd0};
        dir_req[5]  = '{1'b1, 64'hFF00_0000_0000_0041, 4'd1, 32'd1};
        dir_req[6]  = '{1'b0, 64'h41, 4'd1, 32'd7};
        dir_req[7]  = '{1'b1, 64'h0, 4'd3, 32'h3};
        dir_req[8]  = '{1'b0, 64'h0, 4'd2, 32'h0};
        dir_req[9]  = '{1'b1, 64'h0001_0000, 4'd4, 32'h4};
        dir_req[10] = '{1'b1, 64'h6261, 4'd2, 32'h5};
        dir_req[11] = '{1'b1, 64'h6362, 4'd2, 32'h6};
        dir_req[12] = '{1'b1, 64'h6463, 4'd2, 32'h7};
        dir_req[13] = '{1'b1, 64'h6564, 4'd2, 32'h8};
        dir_req[14] = '{1'b1, 64'h6665, 4'd2, 32'h9};
        dir_req[15] = '{1'b1, 64'h41, 4'd1, 32'hFFFF_FFFF};
        for (int r = 0; r < DIR_ROWS; r++) dir_known[r] = 0;
        dir_known[0] = 1; dir_rsp[0] = '{ST_MISS, 32'd0, 1'b0};
        dir_known[1] = 1; dir_rsp[1] = '{ST_OK, 32'd0, 1'b1};
        dir_known[2] = 1; dir_rsp[2] = '{ST_OK, ~32'd0, 1'b0};
        dir_known[4] = 1; dir_rsp[4] = '{ST_OK, 32'hA5A5_5A5A, 1'b0};
        dir_known[15] = 1; dir_rsp[15] = '{ST_OK, 32'd0, 1'b0};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_known[r]) begin
                void'(table_access(dir_req[r]));
                pending_rsp.push_back(dir_rsp[r]);
            end else begin
                pending_rsp.push_back(table_access(dir_req[r]));
            end
            send_request(dir_req[r]);
        end
        // new key once table is half full must be refused
        req = '{1'b1, 64'h7777, 4'd2, 32'h1};
        pending_rsp.push_back(table_access(req));
        send_request(req);
        i_valid <= 1'b0;
        // pause until drained; the dut is not reset, so the model's picture is unchanged
        wait (pending_rsp.size() == 0);
        @(negedge i_clk);

        // random part in bursts; long receiver hold-off partway through
        for (int n = 0; n < RAND_ITEMS; ) begin
            if (n >= 300 && !hold_sent) begin
                long_hold = 1;
                hold_sent = 1;
            end
            if (n >= 900 && !drained) begin
                wait (pending_rsp.size() == 0);
                @(negedge i_clk);
                drained = 1;
            end
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < RAND_ITEMS; b++, n++) begin
                req = random_request();
                pending_rsp.push_back(table_access(req));
                i_req   <= req;
                i_valid <= 1'b1;
                do @(posedge i_clk); while (!o_ready);
                @(negedge i_clk);
            end
            // valid drops only where a gap follows
            if ((n >= 900 && !drained) || n >= RAND_ITEMS || $urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
        stim_done = 1;
    end

    // receiver stall pattern with one long hold-off
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 0;
            end
            case ($urandom_range(0, 3))
                0: i_ready <= 1'b0;
                default: i_ready <= 1'b1;
            endcase
        end
    end

    // response checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("response with nothing expected: %p", o_rsp);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_rsp.status);
                    errors++;
                end
                if (o_rsp.found_value !== want.found_value) begin
                    $error("found_value expected %h actual %h",
                           want.found_value, o_rsp.found_value);
                    errors++;
                end
                if (o_rsp.added_new !== want.added_new) begin
                    $error("added_new expected %0d actual %0d", want.added_new, o_rsp.added_new);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("hashed_key_value_table_unit verification failed");
            $finish;
        end
    end

    // end of run
    initial begin
        idle_cycles = 0;
        wait (stim_done);
        wait (pending_rsp.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("hashed_key_value_table_unit verification clean");
        end else begin
            $display("hashed_key_value_table_unit verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
design/hkvt_pkg.sv
design/hkvt_ram.sv
design/hkvt_front.sv
design/hkvt_fifo.sv
design/hkvt_back.sv
design/hashed_key_value_table_unit.sv
bench/testbench.sv
